// ----- rtl/hsvrgb_pkg.sv -----
// Shared types and constants for the HSV to RGB converter pipeline.
// No dependencies; every other file imports this package.
package hsvrgb_pkg;

	localparam int HueW     = 15;
	localparam int CodeW    = 8;
	localparam int SectorW  = 4;
	localparam int RemW     = 12;
	localparam int ProdW    = 16;
	localparam int NumW     = 28;
	localparam int ScaledW  = 20;
	localparam int RecipW   = 21;
	localparam int QuoW     = 9;
	localparam int Sectors  = 8;
	localparam int Channels = 3;

	localparam int unsigned SectorSpan = 3840;
	localparam int unsigned CodeMax    = 255;
	localparam int unsigned RecipShift = 32;
	localparam int unsigned DropBits   = 8;

	localparam logic [RecipW-1:0] RecipMul = 21'd1122868;

	localparam logic [SectorW-1:0] SecRedGreen = 4'd0;
	localparam logic [SectorW-1:0] SecGreenRed = 4'd1;
	localparam logic [SectorW-1:0] SecGreenBlu = 4'd2;
	localparam logic [SectorW-1:0] SecBluGreen = 4'd3;
	localparam logic [SectorW-1:0] SecBluRed   = 4'd4;

	localparam int InDataW  = 32;
	localparam int OutDataW = 24;

	typedef struct packed {
		logic [CodeW-1:0] brightness;
		logic [CodeW-1:0] saturation;
		logic [HueW-1:0]  hue;
	} pixel_t;

	typedef struct packed {
		logic [CodeW-1:0]   brightness;
		logic [CodeW-1:0]   saturation;
		logic [RemW-1:0]    rem;
		logic [SectorW-1:0] sector;
	} sect_t;

	typedef struct packed {
		logic [ProdW-1:0]              chroma;
		logic [ProdW-1:0]              offset;
		logic [Channels-1:0][RemW-1:0] gain;
	} weight_t;

endpackage

// ----- rtl/hsvrgb_sector.sv -----
// First stage: split hue into 60-degree sector and position within it.
// Depends on hsvrgb_pkg.
module hsvrgb_sector (
	input  logic                  clk,
	input  logic                  en,
	input  hsvrgb_pkg::pixel_t    pixel,
	output hsvrgb_pkg::sect_t     sect_s1
);
	import hsvrgb_pkg::*;

	logic [SectorW-1:0] sec;
	logic [HueW-1:0]    base;

	always_comb begin
		sec  = '0;
		base = '0;
		for (int k = 1; k <= Sectors; k++) begin
			if (pixel.hue >= HueW'(k * SectorSpan)) begin
				sec  = SectorW'(k);
				base = HueW'(k * SectorSpan);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sect_s1.sector     <= sec;
			sect_s1.rem        <= RemW'(pixel.hue - base);
			sect_s1.saturation <= pixel.saturation;
			sect_s1.brightness <= pixel.brightness;
		end
	end

endmodule

// ----- rtl/hsvrgb_weight.sv -----
// Second stage: chroma and offset products, per-channel gain selection.
// Depends on hsvrgb_pkg.
module hsvrgb_weight (
	input  logic                  clk,
	input  logic                  en,
	input  hsvrgb_pkg::sect_t     sect_s1,
	output hsvrgb_pkg::weight_t   weight_s2
);
	import hsvrgb_pkg::*;

	logic [RemW-1:0]  ramp;
	logic [RemW-1:0]  full;
	logic [RemW-1:0]  g_r, g_g, g_b;
	logic [CodeW-1:0] inv_sat;

	assign full    = RemW'(SectorSpan);
	assign ramp    = sect_s1.sector[0] ? RemW'(SectorSpan - sect_s1.rem) : sect_s1.rem;
	assign inv_sat = CodeW'(CodeMax) - sect_s1.saturation;

	always_comb begin
		case (sect_s1.sector)
			SecRedGreen: begin g_r = full; g_g = ramp; g_b = '0;   end
			SecGreenRed: begin g_r = ramp; g_g = full; g_b = '0;   end
			SecGreenBlu: begin g_r = '0;   g_g = full; g_b = ramp; end
			SecBluGreen: begin g_r = '0;   g_g = ramp; g_b = full; end
			SecBluRed:   begin g_r = ramp; g_g = '0;   g_b = full; end
			default:     begin g_r = full; g_g = '0;   g_b = ramp; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			weight_s2.chroma  <= ProdW'(sect_s1.brightness) * ProdW'(sect_s1.saturation);
			weight_s2.offset  <= ProdW'(sect_s1.brightness) * ProdW'(inv_sat);
			weight_s2.gain[0] <= g_r;
			weight_s2.gain[1] <= g_g;
			weight_s2.gain[2] <= g_b;
		end
	end

endmodule

// ----- rtl/hsvrgb_channel.sv -----
// Stages three to five for one color channel: weighted sum, scale, saturate.
// Depends on hsvrgb_pkg.
module hsvrgb_channel (
	input  logic                          clk,
	input  logic                          en_s3,
	input  logic                          en_s4,
	input  logic                          en_s5,
	input  logic [hsvrgb_pkg::ProdW-1:0]  chroma,
	input  logic [hsvrgb_pkg::ProdW-1:0]  offset,
	input  logic [hsvrgb_pkg::RemW-1:0]   gain,
	output logic [hsvrgb_pkg::CodeW-1:0]  level_s5
);
	import hsvrgb_pkg::*;

	logic [NumW-1:0]           prod_s3;
	logic [NumW-1:0]           offs_s3;
	logic [NumW-1:0]           sum;
	logic [ScaledW-1:0]        num_s4;
	logic [ScaledW+RecipW-1:0] recip;
	logic [QuoW-1:0]           quo;

	assign sum   = prod_s3 + offs_s3;
	assign recip = (ScaledW+RecipW)'(num_s4) * (ScaledW+RecipW)'(RecipMul);
	assign quo   = recip[RecipShift +: QuoW];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3 <= NumW'(chroma) * NumW'(gain);
			offs_s3 <= (NumW'(offset) << 12) - (NumW'(offset) << 8);
		end
		if (en_s4) begin
			num_s4 <= sum[DropBits +: ScaledW];
		end
		if (en_s5) begin
			level_s5 <= (quo > QuoW'(CodeMax)) ? CodeW'(CodeMax) : quo[CodeW-1:0];
		end
	end

endmodule

// ----- rtl/hsv_to_rgb_converter.sv -----
// Top level of the HSV to RGB converter: handshake, valid pipeline, channels.
// Depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_weight and hsvrgb_channel.
//
// Usage:
//   Input stream s_*: one pixel per transaction. s_tdata bits [14:0] hue in
//   1/64 degree, [22:15] saturation code, [30:23] brightness code, [31] zero.
//   Output stream m_*: one color per transaction. m_tdata bits [7:0] red,
//   [15:8] green, [23:16] blue.
//   An accepted pixel passes the stage registers s1 to s5 in order, and
//   m_tvalid rises once it reaches s5. Throughput is one pixel per cycle
//   while m_tready is high, set by a five-stage pipeline with one register
//   set per stage: sector split, products and gain select, weighted
//   multiply, sum, reciprocal scale with saturation.
//   Each stage advances when it is empty or the next stage advances, so
//   bubbles close up while the receiver stalls; s_tready drops only when all
//   five stages hold a pixel and m_tready is low. A stalled result is held
//   unchanged on m_tdata.
//   Reset clears all valid bits; the block keeps no other state and accepts
//   input as soon as reset is released.
module hsv_to_rgb_converter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hsvrgb_pkg::InDataW-1:0]    s_tdata,  // hue, saturation, brightness
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hsvrgb_pkg::OutDataW-1:0]   m_tdata   // red, green, blue
);
	import hsvrgb_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	pixel_t                        pixel;
	sect_t                         sect_s1;
	weight_t                       weight_s2;
	logic [Channels-1:0][CodeW-1:0] level_s5;

	assign en_s5 = !valid_s5 || m_tready;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign s_tready = en_s1;
	assign m_tvalid = valid_s5;
	assign m_tdata  = level_s5;
	assign pixel    = s_tdata[$bits(pixel_t)-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_tvalid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	hsvrgb_sector u_sector (
		.clk     (clk),
		.en      (en_s1),
		.pixel   (pixel),
		.sect_s1 (sect_s1)
	);

	hsvrgb_weight u_weight (
		.clk       (clk),
		.en        (en_s2),
		.sect_s1   (sect_s1),
		.weight_s2 (weight_s2)
	);

	for (genvar c = 0; c < Channels; c++) begin : g_chan
		hsvrgb_channel u_channel (
			.clk      (clk),
			.en_s3    (en_s3),
			.en_s4    (en_s4),
			.en_s5    (en_s5),
			.chroma   (weight_s2.chroma),
			.offset   (weight_s2.offset),
			.gain     (weight_s2.gain[c]),
			.level_s5 (level_s5[c])
		);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && !m_tready))
		else $error("input stalled while pipeline has room");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en_s4) |=> valid_s3)
		else $error("held pixel dropped in stage three");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted pixel not captured");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && en_s5) |=> m_tvalid)
		else $error("pixel lost between stage four and output");

endmodule

// ----- test/hsvrgb_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for hsv_to_rgb_converter: watches both stream channels, predicts each color.
// Depends on hsvrgb_pkg for field widths, sector codes and the pixel layout.
module hsvrgb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [hsvrgb_pkg::InDataW-1:0]  s_tdata,   // hue, saturation, brightness
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [hsvrgb_pkg::OutDataW-1:0] m_tdata,   // red, green, blue
	output int                              mismatches,
	output int                              colors_due
);
	import hsvrgb_pkg::*;

	typedef struct packed {
		logic [CodeW-1:0] blue;
		logic [CodeW-1:0] green;
		logic [CodeW-1:0] red;
	} color_t;

	color_t color_q[$];

	initial begin
		mismatches = 0;
		colors_due = 0;
	end

	function automatic logic [CodeW-1:0] scale_channel(int unsigned v, int unsigned s,
		int unsigned g);
		longint unsigned num;
		longint unsigned quo;
		num = longint'(v) * (CodeMax - s) * SectorSpan + longint'(v) * s * g;
		quo = num / (longint'(CodeMax) * SectorSpan);
		if (quo > CodeMax)
			quo = CodeMax;
		return quo[CodeW-1:0];
	endfunction

	function automatic color_t predict_color(pixel_t px);
		int unsigned sector;
		int unsigned rem;
		int unsigned ramp;
		int unsigned gr, gg, gb;
		color_t c;
		sector = px.hue / SectorSpan;
		rem    = px.hue % SectorSpan;
		ramp   = sector[0] ? SectorSpan - rem : rem;
		case (sector[SectorW-1:0])
			SecRedGreen: begin gr = SectorSpan; gg = ramp;       gb = 0;          end
			SecGreenRed: begin gr = ramp;       gg = SectorSpan; gb = 0;          end
			SecGreenBlu: begin gr = 0;          gg = SectorSpan; gb = ramp;       end
			SecBluGreen: begin gr = 0;          gg = ramp;       gb = SectorSpan; end
			SecBluRed:   begin gr = ramp;       gg = 0;          gb = SectorSpan; end
			default:     begin gr = SectorSpan; gg = 0;          gb = ramp;       end
		endcase
		c.red   = scale_channel(px.brightness, px.saturation, gr);
		c.green = scale_channel(px.brightness, px.saturation, gg);
		c.blue  = scale_channel(px.brightness, px.saturation, gb);
		return c;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		color_t got;
		color_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (color_q.size() == 0) begin
					report_mismatch("unexpected color transaction, m_tdata", got, 0);
				end else begin
					want = color_q.pop_front();
					if (got.red !== want.red)
						report_mismatch("red", got.red, want.red);
					if (got.green !== want.green)
						report_mismatch("green", got.green, want.green);
					if (got.blue !== want.blue)
						report_mismatch("blue", got.blue, want.blue);
				end
			end
			if (s_tvalid && s_tready)
				color_q.push_back(predict_color(pixel_t'(s_tdata[$bits(pixel_t)-1:0])));
			colors_due <= color_q.size();
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Top of the hsv_to_rgb_converter regression: clock, reset, pixel stimulus, receiver stalls.
// Depends on hsvrgb_pkg, the converter RTL and hsvrgb_checker.
module tb;
	import hsvrgb_pkg::*;

	localparam int CycleLimit  = 600000;
	localparam int RandomItems = 1900;
	localparam int BlockItems  = 100;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;

	int mismatches;
	int colors_due;
	int cycle_count;
	int tx_idle_pct;
	int rx_idle_pct;
	int stall_left;

	hsv_to_rgb_converter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hsvrgb_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.colors_due (colors_due)
	);

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		cycle_count = 0;
		stall_left  = 0;
		tx_idle_pct = 30;
		rx_idle_pct = 30;
	end

	always #6 clk = ~clk;

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("hsv_to_rgb_converter regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if ($urandom_range(0, 99) < rx_idle_pct) begin
			stall_left <= pick_gap() - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_pixel(input logic [HueW-1:0] hue, input logic [CodeW-1:0] sat,
		input logic [CodeW-1:0] bri);
		int gap;
		gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, bri, sat, hue};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_colors();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (colors_due != 0);
	endtask

	function automatic logic [CodeW-1:0] pick_code();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return CodeW'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [HueW-1:0] pick_hue();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 8)
			return HueW'($urandom_range(0, 32767));
		if (k < 18)
			return HueW'($urandom_range(0, 5) * SectorSpan + $urandom_range(0, 2) - 1 +
				($urandom_range(0, 5) == 0 ? 0 : 1));
		return HueW'($urandom_range(0, 23039));
	endfunction

	initial begin
		int mode;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(15'd0,     8'd255, 8'd255);
		send_pixel(15'd3839,  8'd255, 8'd255);
		send_pixel(15'd3840,  8'd255, 8'd255);
		send_pixel(15'd1920,  8'd255, 8'd255);
		send_pixel(15'd7679,  8'd255, 8'd255);
		send_pixel(15'd7680,  8'd200, 8'd180);
		send_pixel(15'd11520, 8'd255, 8'd128);
		send_pixel(15'd13440, 8'd255, 8'd255);
		send_pixel(15'd15360, 8'd100, 8'd255);
		send_pixel(15'd19200, 8'd255, 8'd255);
		send_pixel(15'd21120, 8'd51,  8'd255);
		send_pixel(15'd23039, 8'd255, 8'd255);
		send_pixel(15'd23040, 8'd255, 8'd255);
		send_pixel(15'd26880, 8'd255, 8'd255);
		send_pixel(15'd28800, 8'd170, 8'd255);
		send_pixel(15'd32767, 8'd255, 8'd255);
		send_pixel(15'd5000,  8'd0,   8'd255);
		send_pixel(15'd5000,  8'd0,   8'd0);
		send_pixel(15'd5000,  8'd255, 8'd0);
		send_pixel(15'd9000,  8'd1,   8'd1);
		send_pixel(15'd17000, 8'd254, 8'd254);
		send_pixel(15'd12345, 8'd85,  8'd170);

		for (int i = 0; i < RandomItems; i++) begin
			if (i % BlockItems == 0) begin
				mode        = $urandom_range(0, 3);
				tx_idle_pct = mode[0] ? $urandom_range(10, 60) : 0;
				rx_idle_pct = mode[1] ? $urandom_range(10, 60) : 0;
			end
			if (i == RandomItems / 2)
				drain_colors();
			send_pixel(pick_hue(), pick_code(), pick_code());
		end

		drain_colors();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && colors_due == 0)
			$display("hsv_to_rgb_converter regression: pass");
		else
			$display("hsv_to_rgb_converter regression: fail");
		$finish;
	end

endmodule
